@@ rtl/core/nic_rx_ring_deframer_core_macros.svh @@
// Assertion macros for the receive ring deframer checker.
// Each macro expects aclk in scope; all but RDF_ASSERT_NXT_ALWAYS also expect aresetn.
`ifndef NIC_RX_RING_DEFRAMER_CORE_MACROS_SVH
`define NIC_RX_RING_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is held
`define RDF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, ignored while reset is held
`define RDF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication that also covers the reset cycles
`define RDF_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ rtl/core/rdf_pkg.sv @@
// Shared types and constants for the receive ring deframer.
// No dependencies; used by rdf_parse and the top level.
package rdf_pkg;

    localparam int unsigned RING_BYTES = 8192;
    localparam int unsigned OFFSET_W   = $clog2(RING_BYTES);
    localparam int unsigned ACK_GAP    = 16;
    localparam int unsigned RX_OK_BIT  = 0;

    // Header byte positions, little endian status then length
    localparam logic [1:0] HDR_STATUS_LO = 2'd0;
    localparam logic [1:0] HDR_STATUS_HI = 2'd1;
    localparam logic [1:0] HDR_LEN_LO    = 2'd2;
    localparam logic [1:0] HDR_LEN_HI    = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_BODY   = 2'b10
    } phase_t;

    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [7:0]          data;
        logic                last;
        logic                ok;
        logic [OFFSET_W-1:0] next_off;
        logic [OFFSET_W-1:0] ack_off;
    } rdf_result_t;

endpackage

@@ rtl/core/rdf_parse.sv @@
// Frame parser: header assembly, body counting and report generation.
// Depends on rdf_pkg.
module rdf_parse
    import rdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  ring_byte,
    output rdf_result_t result
);

    phase_t              phase_reg, phase_next;
    logic [1:0]          hdr_cnt_reg, hdr_cnt_next;
    logic                ok_reg, ok_next;
    logic [15:0]         len_reg, len_next;
    logic [16:0]         cnt_reg, cnt_next;
    logic [OFFSET_W-1:0] rd_off_reg, rd_off_next;

    logic [17:0]         idx_p4;
    logic [17:0]         idx_p5;
    logic [17:0]         len_round;
    logic                is_end;
    logic                is_pay;
    logic                is_last_pay;
    logic [16:0]         off_sum;
    logic [OFFSET_W-1:0] next_off;
    logic [OFFSET_W-1:0] ack_off;

    // Body ends when idx + 1 >= round4(len + 7) - 4
    assign idx_p4      = {1'b0, cnt_reg} + 18'd4;
    assign idx_p5      = {1'b0, cnt_reg} + 18'd5;
    assign len_round   = ({2'b00, len_reg} + 18'd7) & ~18'd3;
    assign is_end      = idx_p5 >= len_round;
    assign is_pay      = idx_p4 < {2'b00, len_reg};
    assign is_last_pay = idx_p5 == {2'b00, len_reg};

    assign off_sum  = 17'(rd_off_reg) + {1'b0, len_reg} + 17'd7;
    assign next_off = {off_sum[OFFSET_W-1:2], 2'b00};
    assign ack_off  = next_off - OFFSET_W'(ACK_GAP);

    always_comb begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        ok_next      = ok_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        rd_off_next  = rd_off_reg;
        result       = '0;

        case (phase_reg)
            PH_BODY: begin
                if (is_end) begin
                    result.valid    = 1'b1;
                    result.kind     = KIND_REPORT;
                    result.ok       = ok_reg;
                    result.next_off = next_off;
                    result.ack_off  = ack_off;
                end else if (ok_reg && is_pay) begin
                    result.valid = 1'b1;
                    result.kind  = KIND_PAYLOAD;
                    result.data  = ring_byte;
                    result.last  = is_last_pay;
                    result.ok    = 1'b1;
                end
                if (step) begin
                    cnt_next = cnt_reg + 17'd1;
                    if (is_end) begin
                        rd_off_next  = next_off;
                        phase_next   = PH_HEADER;
                        hdr_cnt_next = HDR_STATUS_LO;
                        cnt_next     = '0;
                    end
                end
            end
            default: begin
                // header bytes never give a result
                if (step) begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    case (hdr_cnt_reg)
                        HDR_STATUS_LO: ok_next = ring_byte[RX_OK_BIT];
                        HDR_STATUS_HI: ok_next = ok_reg;
                        HDR_LEN_LO:    len_next = {8'h00, ring_byte};
                        default: begin
                            len_next   = {ring_byte, len_reg[7:0]};
                            cnt_next   = '0;
                            phase_next = PH_BODY;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= HDR_STATUS_LO;
            ok_reg      <= 1'b0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            rd_off_reg  <= '0;
        end else begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            ok_reg      <= ok_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            rd_off_reg  <= rd_off_next;
        end
    end

endmodule

@@ rtl/core/nic_rx_ring_deframer_core.sv @@
// Receive ring deframer: one ring byte per cycle, input register then result register.
// A byte's result, if any, enters the result register when that register is free.
// Throughput: one ring byte per cycle while m_ready does not stall the output.
// Back-pressure on m_ready stalls the input register and then s_ready.
// Reset (aresetn low, synchronous) empties both registers and returns to header parsing.
// Depends on rdf_pkg and rdf_parse.
module nic_rx_ring_deframer_core
    import rdf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_ring_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_item_kind,
    output logic [7:0]          m_payload_byte,
    output logic                m_last_byte,
    output logic                m_frame_ok,
    output logic [OFFSET_W-1:0] m_next_read_offset,
    output logic [OFFSET_W-1:0] m_ack_offset
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    rdf_result_t out_reg;
    rdf_result_t result;
    logic        out_free;
    logic        step;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step;

    rdf_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .ring_byte (in_byte_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_ring_byte;
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_item_kind        = out_reg.kind;
    assign m_payload_byte     = out_reg.data;
    assign m_last_byte        = out_reg.last;
    assign m_frame_ok         = out_reg.ok;
    assign m_next_read_offset = out_reg.next_off;
    assign m_ack_offset       = out_reg.ack_off;

endmodule

@@ rtl/core/rdf_checker.sv @@
// Port-level checks for the receive ring deframer, bound to the top level.
// Depends on rdf_pkg and nic_rx_ring_deframer_core_macros.svh.
`include "nic_rx_ring_deframer_core_macros.svh"

module rdf_checker
    import rdf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_item_kind,
    input logic [7:0]          m_payload_byte,
    input logic                m_last_byte,
    input logic                m_frame_ok,
    input logic [OFFSET_W-1:0] m_next_read_offset,
    input logic [OFFSET_W-1:0] m_ack_offset
);

    logic [OFFSET_W-1:0]     ack_expect;
    logic [2*OFFSET_W+10:0]  out_word;
    logic                    is_report;
    logic                    is_payload;
    logic                    ack_ok;
    logic                    report_clean;
    logic                    payload_clean;

    assign ack_expect    = m_next_read_offset - OFFSET_W'(ACK_GAP);
    assign out_word      = {m_item_kind, m_payload_byte, m_last_byte, m_frame_ok,
                            m_next_read_offset, m_ack_offset};
    assign is_report     = m_valid && (m_item_kind == KIND_REPORT);
    assign is_payload    = m_valid && (m_item_kind == KIND_PAYLOAD);
    assign ack_ok        = (m_ack_offset == ack_expect) && (m_next_read_offset[1:0] == 2'b00);
    assign report_clean  = (m_payload_byte == 8'h00) && !m_last_byte;
    assign payload_clean = m_frame_ok && (m_next_read_offset == '0) && (m_ack_offset == '0);

    `RDF_ASSERT_NXT_ALWAYS(a_reset_empty, !aresetn, !m_valid)
    `RDF_ASSERT_NXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(out_word))
    `RDF_ASSERT_IMP(a_report_ack, is_report, ack_ok)
    `RDF_ASSERT_IMP(a_report_clean, is_report, report_clean)
    `RDF_ASSERT_IMP(a_payload_clean, is_payload, payload_clean)

endmodule

bind nic_rx_ring_deframer_core rdf_checker u_rdf_checker (.*);

@@ sim/nic_rx_ring_deframer_core_test.sv @@
// Self-checking testbench for nic_rx_ring_deframer_core: frames go in as ring bytes,
// payload bytes and frame reports are predicted and checked in order.
// Depends on rdf_pkg and the core RTL.
module nic_rx_ring_deframer_core_test;
    import rdf_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned MAX_REPORTED    = 10;
    localparam int unsigned BYTES_PER_PHASE = 150;

    typedef enum int unsigned {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct packed {
        logic                kind;
        logic [7:0]          data;
        logic                last;
        logic                ok;
        logic [OFFSET_W-1:0] next_off;
        logic [OFFSET_W-1:0] ack_off;
    } rx_item_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_ring_byte;
    logic                m_valid;
    logic                m_ready;
    logic                m_item_kind;
    logic [7:0]          m_payload_byte;
    logic                m_last_byte;
    logic                m_frame_ok;
    logic [OFFSET_W-1:0] m_next_read_offset;
    logic [OFFSET_W-1:0] m_ack_offset;

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned mismatches;
    int unsigned idle_cycles;

    // Deframer state as the testbench sees it
    phase_t              pred_phase;
    logic [1:0]          pred_hdr_pos;
    logic [15:0]         pred_status;
    logic [15:0]         pred_length;
    logic [16:0]         pred_body_cnt;
    logic [OFFSET_W-1:0] pred_rd_off;

    rx_item_t expected_items[$];

    nic_rx_ring_deframer_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_ring_byte        (s_ring_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_item_kind        (m_item_kind),
        .m_payload_byte     (m_payload_byte),
        .m_last_byte        (m_last_byte),
        .m_frame_ok         (m_frame_ok),
        .m_next_read_offset (m_next_read_offset),
        .m_ack_offset       (m_ack_offset)
    );

    always #1 aclk = ~aclk;

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            $display("%s", msg);
        end
    endfunction

    // Advance the deframer by one accepted ring byte and queue what it emits
    function automatic void deframe_ring_byte(input logic [7:0] b);
        int unsigned idx;
        int unsigned len;
        int unsigned body_len;
        int unsigned pay_len;
        int unsigned new_off;
        int unsigned rd;
        logic        good;
        rx_item_t    item;
        if (pred_phase != PH_BODY) begin
            case (pred_hdr_pos)
                HDR_STATUS_LO: pred_status = {8'h00, b};
                HDR_STATUS_HI: pred_status[15:8] = b;
                HDR_LEN_LO:    pred_length = {8'h00, b};
                default:       pred_length[15:8] = b;
            endcase
            if (pred_hdr_pos == HDR_LEN_HI) begin
                pred_hdr_pos  = HDR_STATUS_LO;
                pred_body_cnt = '0;
                pred_phase    = PH_BODY;
            end else begin
                pred_hdr_pos = pred_hdr_pos + 2'd1;
            end
        end else begin
            idx      = pred_body_cnt;
            len      = pred_length;
            rd       = pred_rd_off;
            body_len = ((len + 7) & ~32'd3) - 4;
            pay_len  = (len >= 4) ? len - 4 : 0;
            good     = pred_status[RX_OK_BIT];
            pred_body_cnt = pred_body_cnt + 17'd1;
            if (idx + 1 >= body_len) begin
                new_off       = ((rd + len + 7) & ~32'd3) % RING_BYTES;
                item.kind     = KIND_REPORT;
                item.data     = '0;
                item.last     = 1'b0;
                item.ok       = good;
                item.next_off = new_off[OFFSET_W-1:0];
                item.ack_off  = OFFSET_W'((new_off + RING_BYTES - ACK_GAP) % RING_BYTES);
                pred_rd_off   = new_off[OFFSET_W-1:0];
                pred_phase    = PH_HEADER;
                pred_hdr_pos  = HDR_STATUS_LO;
                pred_body_cnt = '0;
                expected_items.push_back(item);
            end else if (good && idx < pay_len) begin
                item.kind     = KIND_PAYLOAD;
                item.data     = b;
                item.last     = (idx + 1 == pay_len);
                item.ok       = 1'b1;
                item.next_off = '0;
                item.ack_off  = '0;
                expected_items.push_back(item);
            end
        end
    endfunction

    // Predict on accepted requests, check each accepted result against the oldest one
    always @(posedge aclk) begin
        rx_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                deframe_ring_byte(s_ring_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_items.size() == 0) begin
                    log_mismatch($sformatf(
                        "unexpected result: kind %0d data %02h last %0d ok %0d next %0d ack %0d",
                        m_item_kind, m_payload_byte, m_last_byte, m_frame_ok,
                        m_next_read_offset, m_ack_offset));
                end else begin
                    want = expected_items.pop_front();
                    if (m_item_kind !== want.kind || m_payload_byte !== want.data ||
                        m_last_byte !== want.last || m_frame_ok !== want.ok ||
                        m_next_read_offset !== want.next_off ||
                        m_ack_offset !== want.ack_off) begin
                        log_mismatch($sformatf(
                            {"mismatch: expected kind %0d data %02h last %0d ok %0d next %0d ",
                             "ack %0d, got kind %0d data %02h last %0d ok %0d next %0d ack %0d"},
                            want.kind, want.data, want.last, want.ok, want.next_off,
                            want.ack_off, m_item_kind, m_payload_byte, m_last_byte,
                            m_frame_ok, m_next_read_offset, m_ack_offset));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Drop the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("nic_rx_ring_deframer_core_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_ring_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_ring_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_rx_frame(input logic [15:0] status, input logic [15:0] length,
                                 input fill_t fill);
        int unsigned len;
        int unsigned body_len;
        logic [7:0]  b;
        len      = length;
        body_len = ((len + 7) & ~32'd3) - 4;
        if (body_len == 0) begin
            // a zero length still takes one body byte to close the frame
            body_len = 1;
        end
        send_ring_byte(status[7:0]);
        send_ring_byte(status[15:8]);
        send_ring_byte(length[7:0]);
        send_ring_byte(length[15:8]);
        for (int unsigned i = 0; i < body_len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            send_ring_byte(b);
        end
    endtask

    // Lengths below four, exactly four and just above
    task automatic test_short_and_empty_frames;
        for (int unsigned len = 0; len <= 5; len++) begin
            send_rx_frame(16'h0001, 16'(len), FILL_RANDOM);
        end
    endtask

    task automatic test_status_and_payload_extremes;
        send_rx_frame(16'h0000, 16'd20, FILL_RANDOM);
        send_rx_frame(16'hFFFE, 16'd9, FILL_ONES);
        send_rx_frame(16'hFFFF, 16'd9, FILL_ONES);
        send_rx_frame(16'h0001, 16'd12, FILL_ZERO);
        send_rx_frame(16'h8001, 16'd7, FILL_RANDOM);
    endtask

    // A long frame with a bad status, then a long good frame
    task automatic test_long_frames;
        send_rx_frame(16'h0000, 16'd200, FILL_RANDOM);
        send_rx_frame(16'h0001, 16'd200, FILL_RANDOM);
    endtask

    task automatic test_random_frames(input int unsigned s_pct, input int unsigned r_pct);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        logic [15:0] status;
        sender_idle_pct    = s_pct;
        receiver_stall_pct = r_pct;
        sent = 0;
        while (sent < BYTES_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                len = $urandom_range(4, 0);
            end else if (pick < 80) begin
                len = $urandom_range(40, 5);
            end else if (pick < 95) begin
                len = $urandom_range(120, 41);
            end else begin
                len = $urandom_range(400, 121);
            end
            status = 16'($urandom);
            status[RX_OK_BIT] = ($urandom_range(99) < 75);
            send_rx_frame(status, 16'(len), FILL_RANDOM);
            sent += ((len + 7) & ~32'd3);
        end
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_ring_byte        = 8'h00;
        m_ready            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatches         = 0;
        idle_cycles        = 0;
        pred_phase         = PH_HEADER;
        pred_hdr_pos       = HDR_STATUS_LO;
        pred_status        = '0;
        pred_length        = '0;
        pred_body_cnt      = '0;
        pred_rd_off        = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_short_and_empty_frames();
        test_status_and_payload_extremes();
        test_long_frames();
        test_random_frames(0, 0);
        test_random_frames(55, 0);
        test_random_frames(0, 55);
        test_random_frames(22, 22);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_items.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_items.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", expected_items.size()));
        end
        if (mismatches == 0) begin
            $display("nic_rx_ring_deframer_core_test: clean");
        end else begin
            $display("nic_rx_ring_deframer_core_test: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rdf_pkg.sv
rtl/core/rdf_parse.sv
rtl/core/nic_rx_ring_deframer_core.sv
rtl/core/rdf_checker.sv
sim/nic_rx_ring_deframer_core_test.sv
